FILE: src/cml_pkg.sv
// ----------------------------------------------------------------------------
// cml_pkg: shared types of the counter machine lexer
// token kind codes, character classes, scanner modes and queue entry formats
// ----------------------------------------------------------------------------
`default_nettype none

package cml_pkg;

  typedef logic [4:0] kind_t;

  localparam kind_t KIND_END           = 5'd0;
  localparam kind_t KIND_NEWLINE       = 5'd1;
  localparam kind_t KIND_HASH          = 5'd2;
  localparam kind_t KIND_LBRACKET      = 5'd3;
  localparam kind_t KIND_RBRACKET      = 5'd4;
  localparam kind_t KIND_COLON         = 5'd5;
  localparam kind_t KIND_NUMBER        = 5'd6;
  localparam kind_t KIND_FIRST_KEYWORD = 5'd7;
  localparam kind_t KIND_IDENT         = 5'd27;
  localparam kind_t KIND_ERROR         = 5'd28;

  // character classes produced by the front end
  typedef enum logic [2:0] {
    CLS_SKIP,
    CLS_END,
    CLS_PUNCT,
    CLS_DIGIT,
    CLS_LETTER,
    CLS_BAD
  } cls_e;

  // one classified character; kind is valid for end and punctuation
  typedef struct packed {
    cls_e        cls;
    logic [7:0]  code;
    kind_t       kind;
  } cls_beat_t;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_NUMBER,
    MODE_WORD,
    MODE_ERROR
  } mode_e;

  typedef struct packed {
    kind_t        kind;
    logic [62:0]  value;
    logic         overflow;
    logic [63:0]  text;
    logic [7:0]   length;
  } token_t;

  // a second token is always a bare delimiter token, so only its kind is kept
  typedef struct packed {
    token_t  first;
    logic    has_second;
    kind_t   second;
  } tq_entry_t;

endpackage

`default_nettype wire

FILE: src/counter_machine_lexer_unit.sv
// ----------------------------------------------------------------------------
// counter_machine_lexer_unit: streaming lexer for a counter machine language
// one source byte per input beat, tokens out of a result queue
// ----------------------------------------------------------------------------
// input channel: push / full with char_code_i; a byte is taken at an edge
//   with push high and full low. a NUL byte ends the program
// result channel: empty / pop; the oldest token sits on the token ports
//   while empty is low and leaves at an edge with pop high
// path: a taken byte waits in the classifier queue, then the scanner writes
//   its tokens into the token queue, whose head drives the ports
// throughput: one byte per cycle while the token queue has a free slot; a byte may close a run and give
//   two tokens, which then leave over two pop beats. the scanner takes a byte
//   whenever the four-entry token queue has a free slot
// when the receiver stalls the token queue fills, the scanner holds, the
//   two-entry byte queue fills and full goes high; nothing is dropped
// reset: both queues empty, scanner idle with a cleared run
// ----------------------------------------------------------------------------
`default_nettype none

module counter_machine_lexer_unit #(
  parameter int TEXT_CHARS = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // input byte queue side
  input  wire logic         push,
  output logic              full,
  input  wire logic [7:0]   char_code_i,
  // token queue side
  output logic              empty,
  input  wire logic         pop,
  output logic [4:0]        token_kind_o,
  output logic [62:0]       number_value_o,
  output logic              number_overflow_o,
  output logic [63:0]       word_text_o,
  output logic [7:0]        word_length_o
);
  import cml_pkg::*;

  // classified byte between front end and scanner
  logic        cls_valid;
  logic        cls_ready;
  cls_beat_t   cls_beat;

  // scanner to token queue
  logic        tq_room;
  logic        tq_write;
  tq_entry_t   tq_entry;
  token_t      head_tok;

  // front end: classify and buffer
  cml_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .char_code_i (char_code_i),
    .out_valid_o (cls_valid),
    .out_beat_o  (cls_beat),
    .out_ready_i (cls_ready)
  );

  // scanner: mode machine, number accumulate, word capture, keyword match
  cml_back #(
    .TEXT_CHARS (TEXT_CHARS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cls_valid),
    .in_beat_i  (cls_beat),
    .in_ready_o (cls_ready),
    .tq_room_i  (tq_room),
    .tq_write_o (tq_write),
    .tq_entry_o (tq_entry)
  );

  // result queue
  cml_tok_queue u_tok_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (tq_write),
    .entry_i (tq_entry),
    .room_o  (tq_room),
    .empty_o (empty),
    .pop_i   (pop),
    .head_o  (head_tok)
  );

  assign token_kind_o      = head_tok.kind;
  assign number_value_o    = head_tok.value;
  assign number_overflow_o = head_tok.overflow;
  assign word_text_o       = head_tok.text;
  assign word_length_o     = head_tok.length;

endmodule

`default_nettype wire

FILE: src/cml_front.sv
// ----------------------------------------------------------------------------
// cml_front: character classifier and input queue
// classifies each accepted byte and holds it until the scanner takes it
// ----------------------------------------------------------------------------
`default_nettype none

module cml_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [7:0]        char_code_i,
  output logic                   out_valid_o,
  output cml_pkg::cls_beat_t     out_beat_o,
  input  wire logic              out_ready_i
);
  import cml_pkg::*;

  localparam int IqDepth = 2;
  localparam int PtrW    = $clog2(IqDepth);
  localparam int CntW    = $clog2(IqDepth + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(IqDepth);

  localparam logic [7:0] CharNul    = 8'h00;
  localparam logic [7:0] CharTab    = 8'h09;
  localparam logic [7:0] CharLf     = 8'h0a;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharHash   = 8'h23;
  localparam logic [7:0] CharColon  = 8'h3a;
  localparam logic [7:0] CharLbrack = 8'h5b;
  localparam logic [7:0] CharRbrack = 8'h5d;

  function automatic cls_beat_t classify(input logic [7:0] c);
    cls_beat_t b;
    b      = '0;
    b.code = c;
    b.kind = KIND_END;
    b.cls  = CLS_BAD;
    case (c)
      CharNul:    b.cls = CLS_END;
      CharTab:    b.cls = CLS_SKIP;
      CharSpace:  b.cls = CLS_SKIP;
      CharLf:     begin b.cls = CLS_PUNCT; b.kind = KIND_NEWLINE;  end
      CharHash:   begin b.cls = CLS_PUNCT; b.kind = KIND_HASH;     end
      CharLbrack: begin b.cls = CLS_PUNCT; b.kind = KIND_LBRACKET; end
      CharRbrack: begin b.cls = CLS_PUNCT; b.kind = KIND_RBRACKET; end
      CharColon:  begin b.cls = CLS_PUNCT; b.kind = KIND_COLON;    end
      default: begin
        if (c >= "0" && c <= "9") begin
          b.cls = CLS_DIGIT;
        end else if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) begin
          b.cls = CLS_LETTER;
        end
      end
    endcase
    return b;
  endfunction

  cls_beat_t          beats_q [IqDepth];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    count_q, count_d;
  logic               wr_en, rd_en;

  assign full        = (count_q == CntFull);
  assign out_valid_o = (count_q != '0);
  assign out_beat_o  = beats_q[rd_ptr_q];
  assign wr_en       = push & ~full;
  assign rd_en       = out_valid_o & out_ready_i;

  always_comb begin
    wr_ptr_d = wr_en ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + CntW'(wr_en) - CntW'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      beats_q[wr_ptr_q] <= classify(char_code_i);
    end
  end

endmodule

`default_nettype wire

FILE: src/cml_back.sv
// ----------------------------------------------------------------------------
// cml_back: scanner
// runs the number / word / error mode machine and builds token entries
// ----------------------------------------------------------------------------
`default_nettype none

module cml_back #(
  parameter int TEXT_CHARS = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire cml_pkg::cls_beat_t in_beat_i,
  output logic                    in_ready_o,
  input  wire logic               tq_room_i,
  output logic                    tq_write_o,
  output cml_pkg::tq_entry_t      tq_entry_o
);
  import cml_pkg::*;

  localparam int StoredChars = (TEXT_CHARS < 8) ? TEXT_CHARS : 8;
  localparam int TextW       = 8 * StoredChars;
  localparam int KwCount     = 20;
  localparam logic [62:0] MaxNumber = {63{1'b1}};

  localparam logic [63:0] KwText [KwCount] = '{
    64'h636e69, 64'h636564, 64'h797063, 64'h726c63, 64'h706d6a,
    64'h646461, 64'h627573, 64'h6c756d, 64'h766964, 64'h666564,
    64'h746573, 64'h6d7273, 64'h6d726c, 64'h6d7275, 64'h6c6c6163,
    64'h6e69616d, 64'h6b61657262, 64'h3074697865, 64'h796b736e696d,
    64'h656e696863616d
  };
  localparam int KwLen [KwCount] = '{
    3, 3, 3, 3, 3, 3, 3, 3, 3, 3, 3, 3, 3, 3, 4, 4, 5, 5, 6, 7
  };

  mode_e              mode_q, mode_d;
  logic [62:0]        acc_q, acc_d;
  logic               ovf_q, ovf_d;
  logic [TextW-1:0]   text_q, text_d;
  logic [7:0]         len_q, len_d;

  logic               take;
  logic               is_delim;
  logic [7:0]         len_inc;
  logic [67:0]        acc_ext, acc_next;
  logic [62:0]        acc_step;
  logic               ovf_step;
  logic [TextW-1:0]   text_step;
  logic [63:0]        text_wide;
  logic               kw_hit;
  kind_t              kw_kind;
  token_t             run_tok;

  assign in_ready_o = tq_room_i;
  assign take       = in_valid_i & tq_room_i;
  assign is_delim   = (in_beat_i.cls == CLS_SKIP) || (in_beat_i.cls == CLS_END) ||
                      (in_beat_i.cls == CLS_PUNCT);
  assign len_inc    = (len_q == 8'hff) ? len_q : len_q + 8'd1;
  assign text_wide  = 64'(text_q);

  // decimal step: acc * 10 + digit, saturating
  always_comb begin
    acc_ext  = {5'b0, acc_q};
    acc_next = (acc_ext << 3) + (acc_ext << 1) + 68'(in_beat_i.code[3:0]);
    if (ovf_q || (acc_next[67:63] != '0)) begin
      acc_step = MaxNumber;
      ovf_step = 1'b1;
    end else begin
      acc_step = acc_next[62:0];
      ovf_step = 1'b0;
    end
  end

  always_comb begin
    text_step = text_q;
    for (int i = 0; i < StoredChars; i++) begin
      if (len_q == 8'(i)) begin
        text_step[8*i +: 8] = in_beat_i.code;
      end
    end
  end

  always_comb begin
    kw_hit  = 1'b0;
    kw_kind = KIND_IDENT;
    for (int i = 0; i < KwCount; i++) begin
      if (len_q == 8'(KwLen[i]) && KwLen[i] <= TEXT_CHARS && KwText[i] == text_wide) begin
        kw_hit  = 1'b1;
        kw_kind = KIND_FIRST_KEYWORD + 5'(i);
      end
    end
  end

  // token of the run being closed
  always_comb begin
    run_tok = '0;
    if (mode_q == MODE_NUMBER) begin
      run_tok.kind     = KIND_NUMBER;
      run_tok.value    = acc_q;
      run_tok.overflow = ovf_q;
      run_tok.length   = len_q;
    end else if (kw_hit) begin
      run_tok.kind = kw_kind;
    end else begin
      run_tok.kind   = KIND_IDENT;
      run_tok.text   = text_wide;
      run_tok.length = len_q;
    end
  end

  // next mode
  always_comb begin
    mode_d = mode_q;
    if (take) begin
      case (mode_q)
        MODE_IDLE: begin
          case (in_beat_i.cls)
            CLS_DIGIT:  mode_d = MODE_NUMBER;
            CLS_LETTER: mode_d = MODE_WORD;
            CLS_BAD:    mode_d = MODE_ERROR;
            default:    mode_d = MODE_IDLE;
          endcase
        end
        MODE_NUMBER: begin
          if (in_beat_i.cls == CLS_DIGIT) begin
            mode_d = MODE_NUMBER;
          end else if (is_delim) begin
            mode_d = MODE_IDLE;
          end else begin
            mode_d = MODE_ERROR;
          end
        end
        MODE_WORD: begin
          if (in_beat_i.cls == CLS_DIGIT || in_beat_i.cls == CLS_LETTER) begin
            mode_d = MODE_WORD;
          end else if (is_delim) begin
            mode_d = MODE_IDLE;
          end else begin
            mode_d = MODE_ERROR;
          end
        end
        MODE_ERROR: begin
          if (in_beat_i.cls == CLS_END) begin
            mode_d = MODE_IDLE;
          end
        end
        default: mode_d = MODE_IDLE;
      endcase
    end
  end

  // run registers and token output
  always_comb begin
    acc_d      = acc_q;
    ovf_d      = ovf_q;
    text_d     = text_q;
    len_d      = len_q;
    tq_write_o = 1'b0;
    tq_entry_o = '0;
    if (take) begin
      case (mode_q)
        MODE_IDLE: begin
          case (in_beat_i.cls)
            CLS_END, CLS_PUNCT: begin
              tq_write_o            = 1'b1;
              tq_entry_o.first.kind = in_beat_i.kind;
            end
            CLS_DIGIT: begin
              acc_d  = 63'(in_beat_i.code[3:0]);
              ovf_d  = 1'b0;
              text_d = '0;
              len_d  = 8'd1;
            end
            CLS_LETTER: begin
              acc_d       = '0;
              ovf_d       = 1'b0;
              text_d      = '0;
              text_d[7:0] = in_beat_i.code;
              len_d       = 8'd1;
            end
            CLS_BAD: begin
              acc_d                 = '0;
              ovf_d                 = 1'b0;
              text_d                = '0;
              len_d                 = '0;
              tq_write_o            = 1'b1;
              tq_entry_o.first.kind = KIND_ERROR;
            end
            default: ;
          endcase
        end
        MODE_NUMBER, MODE_WORD: begin
          if ((mode_q == MODE_NUMBER && in_beat_i.cls == CLS_DIGIT) ||
              (mode_q == MODE_WORD &&
               (in_beat_i.cls == CLS_DIGIT || in_beat_i.cls == CLS_LETTER))) begin
            if (mode_q == MODE_NUMBER) begin
              acc_d = acc_step;
              ovf_d = ovf_step;
            end else begin
              text_d = text_step;
            end
            len_d = len_inc;
          end else begin
            acc_d      = '0;
            ovf_d      = 1'b0;
            text_d     = '0;
            len_d      = '0;
            tq_write_o = 1'b1;
            if (is_delim) begin
              // run token, then the delimiter's own token if it has one
              tq_entry_o.first      = run_tok;
              tq_entry_o.has_second = (in_beat_i.cls != CLS_SKIP);
              tq_entry_o.second     = in_beat_i.kind;
            end else begin
              tq_entry_o.first.kind = KIND_ERROR;
            end
          end
        end
        MODE_ERROR: begin
          if (in_beat_i.cls == CLS_END) begin
            acc_d                 = '0;
            ovf_d                 = 1'b0;
            text_d                = '0;
            len_d                 = '0;
            tq_write_o            = 1'b1;
            tq_entry_o.first.kind = KIND_END;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      acc_q  <= '0;
      ovf_q  <= 1'b0;
      text_q <= '0;
      len_q  <= '0;
    end else begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      ovf_q  <= ovf_d;
      text_q <= text_d;
      len_q  <= len_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/cml_tok_queue.sv
// ----------------------------------------------------------------------------
// cml_tok_queue: token output queue
// holds scanner entries; an entry with a trailing delimiter pops as two beats
// ----------------------------------------------------------------------------
`default_nettype none

module cml_tok_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               wr_i,
  input  wire cml_pkg::tq_entry_t entry_i,
  output logic                    room_o,
  output logic                    empty_o,
  input  wire logic               pop_i,
  output cml_pkg::token_t         head_o
);
  import cml_pkg::*;

  localparam int TqDepth = 4;
  localparam int PtrW    = $clog2(TqDepth);
  localparam int CntW    = $clog2(TqDepth + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(TqDepth);

  tq_entry_t        entries_q [TqDepth];
  tq_entry_t        head_entry;
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             sub_q, sub_d;
  logic             pop_ok, advance, wr_ok;

  assign room_o     = (count_q != CntFull);
  assign empty_o    = (count_q == '0);
  assign head_entry = entries_q[rd_ptr_q];
  assign pop_ok     = pop_i & ~empty_o;
  assign advance    = pop_ok & (sub_q | ~head_entry.has_second);
  assign wr_ok      = wr_i & room_o;

  always_comb begin
    head_o = head_entry.first;
    if (sub_q) begin
      head_o      = '0;
      head_o.kind = head_entry.second;
    end
  end

  always_comb begin
    wr_ptr_d = wr_ok ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = advance ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + CntW'(wr_ok) - CntW'(advance);
    sub_d    = sub_q;
    if (pop_ok) begin
      sub_d = ~advance;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      sub_q    <= 1'b0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
      sub_q    <= sub_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      entries_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire
